### rtl/core/lsf_pkg.sv
// shared types and constants for the 3x3 laplacian / sobel filter
// no dependencies; imported by every module of the block except lsf_ram
package lsf_pkg;

   // pixel and register port widths
   localparam int PIX_W        = 8;
   localparam int CSR_ADDR_W   = 2;
   localparam int CSR_DATA_W   = 13;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;

   // register indexes on the csr port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_FILTER_MODE  = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   // filter selection
   typedef enum logic {
      MODE_LAPLACIAN = 1'b0,
      MODE_SOBEL     = 1'b1
   } filter_mode_type;

   // input word
   typedef struct packed {
      logic [PIX_W-1:0] pixel_in;
      logic             drain;
   } req_word_type;

   // result word
   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic             end_of_row;
      logic             end_of_frame;
   } rsp_word_type;

   // position status of one accepted word, from counters to window stage
   typedef struct packed {
      logic has_result;
      logic top_edge;
      logic bottom_edge;
      logic left_edge;
      logic right_edge;
      logic end_of_row;
      logic end_of_frame;
   } pos_flags_type;

   // one window column, index 0 is the top row
   typedef logic [2:0][PIX_W-1:0] column_type;

   // 3x3 window as [row][col], row 0 top, col 0 left
   typedef logic [2:0][2:0][PIX_W-1:0] window_type;

endpackage

### rtl/core/lsf_ram.sv
// generic single write port ram with registered read
// no dependencies; used for the line buffers of the filter
module lsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // read returns the old contents on a same address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/core/lsf_ctrl.sv
// configuration registers and raster position counters of the filter
// depends on lsf_pkg
module lsf_ctrl import lsf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  accept,
   output logic [AW-1:0]         col_addr,
   output pos_flags_type         flags,
   output filter_mode_type       mode
);

   localparam int HW = $clog2(MAX_HEIGHT);
   localparam int RW = $clog2(MAX_HEIGHT + 2);
   localparam int WIDTH_RESET  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
   localparam int HEIGHT_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

   filter_mode_type mode_ff, mode_in;
   logic [AW-1:0]   w_last_ff, w_last_in;
   logic [HW-1:0]   h_last_ff, h_last_in;
   logic [AW-1:0]   in_col_ff, in_col_in;
   logic [RW-1:0]   in_row_ff, in_row_in;
   logic [AW-1:0]   out_col_ff, out_col_in;
   logic [HW-1:0]   out_row_ff, out_row_in;

   logic [WIDTH_REG_W-1:0]  wr_width;
   logic [HEIGHT_REG_W-1:0] wr_height;
   logic [AW-1:0]           w_sat_last;
   logic [HW-1:0]           h_sat_last;
   logic                    size_write;
   pos_flags_type           flags_now;

   assign wr_width  = csr_data[WIDTH_REG_W-1:0];
   assign wr_height = csr_data[HEIGHT_REG_W-1:0];

   // clamp written sizes into 1..max and keep size minus one
   always_comb begin
      if (wr_width == '0) begin
         w_sat_last = '0;
      end else if (int'(wr_width) > MAX_WIDTH) begin
         w_sat_last = AW'(MAX_WIDTH - 1);
      end else begin
         w_sat_last = AW'(wr_width - 1'b1);
      end
      if (wr_height == '0) begin
         h_sat_last = '0;
      end else if (int'(wr_height) > MAX_HEIGHT) begin
         h_sat_last = HW'(MAX_HEIGHT - 1);
      end else begin
         h_sat_last = HW'(wr_height - 1'b1);
      end
   end

   // register writes
   always_comb begin
      mode_in    = mode_ff;
      w_last_in  = w_last_ff;
      h_last_in  = h_last_ff;
      size_write = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_FILTER_MODE: begin
               mode_in = filter_mode_type'(csr_data[0]);
            end
            CSR_IMAGE_WIDTH: begin
               w_last_in  = w_sat_last;
               size_write = 1'b1;
            end
            CSR_IMAGE_HEIGHT: begin
               h_last_in  = h_sat_last;
               size_write = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // status of the word at the input: a result once w+1 words are in
   always_comb begin
      flags_now.has_result   = (in_row_ff >= RW'(2)) ||
                               ((in_row_ff == RW'(1)) && (in_col_ff != '0));
      flags_now.top_edge     = (out_row_ff == '0);
      flags_now.bottom_edge  = (out_row_ff == h_last_ff);
      flags_now.left_edge    = (out_col_ff == '0);
      flags_now.right_edge   = (out_col_ff == w_last_ff);
      flags_now.end_of_row   = flags_now.right_edge;
      flags_now.end_of_frame = flags_now.right_edge && flags_now.bottom_edge;
   end

   // position counters
   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (accept) begin
         if (in_col_ff == w_last_ff) begin
            in_col_in = '0;
            in_row_in = RW'(in_row_ff + 1'b1);
         end else begin
            in_col_in = AW'(in_col_ff + 1'b1);
         end
         if (flags_now.has_result) begin
            if (flags_now.end_of_row) begin
               out_col_in = '0;
               out_row_in = HW'(out_row_ff + 1'b1);
            end else begin
               out_col_in = AW'(out_col_ff + 1'b1);
            end
         end
      end
      // frame end or a size change starts a new frame
      if ((accept && flags_now.has_result && flags_now.end_of_frame) || size_write) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_LAPLACIAN;
         w_last_ff  <= AW'(WIDTH_RESET - 1);
         h_last_ff  <= HW'(HEIGHT_RESET - 1);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         w_last_ff  <= w_last_in;
         h_last_ff  <= h_last_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   assign col_addr = in_col_ff;
   assign flags    = flags_now;
   assign mode     = mode_ff;

endmodule

### rtl/core/lsf_filter.sv
// laplacian sharpen and sobel magnitude kernels over one 3x3 window
// depends on lsf_pkg
module lsf_filter import lsf_pkg::*; (
   input  window_type       win,
   input  filter_mode_type  mode,
   output logic [PIX_W-1:0] result
);

   // zero extend a pixel into the signed sum width
   function automatic logic signed [11:0] ext(input logic [PIX_W-1:0] p);
      return $signed({4'b0000, p});
   endfunction

   // magnitude clamped to 255
   function automatic logic [PIX_W-1:0] sat_abs(input logic signed [11:0] v);
      logic [11:0] mag;
      mag = v[11] ? 12'(-v) : 12'(v);
      return (mag > 12'd255) ? 8'd255 : mag[PIX_W-1:0];
   endfunction

   logic signed [11:0] lap, gx, gy;
   logic [PIX_W:0]     sum;
   logic [PIX_W-1:0]   half;

   // kernel sums
   always_comb begin
      lap = 12'sd5 * ext(win[1][1]) - ext(win[0][1]) - ext(win[1][0])
            - ext(win[1][2]) - ext(win[2][1]);
      gx  = ext(win[0][2]) + 12'sd2 * ext(win[1][2]) + ext(win[2][2])
            - ext(win[0][0]) - 12'sd2 * ext(win[1][0]) - ext(win[2][0]);
      gy  = ext(win[2][0]) + 12'sd2 * ext(win[2][1]) + ext(win[2][2])
            - ext(win[0][0]) - 12'sd2 * ext(win[0][1]) - ext(win[0][2]);
   end

   // average of the two magnitudes, ties go to even
   assign sum  = {1'b0, sat_abs(gx)} + {1'b0, sat_abs(gy)};
   assign half = sum[PIX_W:1];

   always_comb begin
      case (mode)
         MODE_LAPLACIAN: result = sat_abs(lap);
         MODE_SOBEL:     result = (sum[0] && half[0]) ? PIX_W'(half + 1'b1) : half;
         default:        result = '0;
      endcase
   end

endmodule

### rtl/core/lsf_window.sv
// line buffers, window stage and result register of the filter
// depends on lsf_pkg, lsf_ram and lsf_filter
module lsf_window import lsf_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int AW = $clog2(MAX_WIDTH)
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  req_word_type    word,
   input  logic [AW-1:0]   col_addr,
   input  pos_flags_type   flags,
   input  filter_mode_type mode,
   output logic            stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_word_type    rsp_data
);

   logic [PIX_W-1:0] pix_now;
   logic [PIX_W-1:0] lb1_q, lb0_q, lb0_eff;
   logic             out_free, b_adv, fwd_now;
   column_type       newcol;
   window_type       win;
   logic [PIX_W-1:0] result;

   logic             b_valid_ff, b_valid_in;
   pos_flags_type    b_flags_ff, b_flags_in;
   logic [PIX_W-1:0] b_pix_ff, b_pix_in;
   logic [AW-1:0]    b_addr_ff, b_addr_in;
   logic             b_fwd_ff, b_fwd_in;
   logic [PIX_W-1:0] b_fwd_data_ff, b_fwd_data_in;
   column_type       sr0_ff, sr0_in, sr1_ff, sr1_in;
   logic             out_valid_ff, out_valid_in;
   rsp_word_type     out_word_ff, out_word_in;

   // a drain word stands for a zero pixel
   assign pix_now = word.drain ? '0 : word.pixel_in;

   // stage handshake
   assign out_free = !out_valid_ff || !rsp_stall;
   assign b_adv    = b_valid_ff && (!b_flags_ff.has_result || out_free);
   assign stall    = b_valid_ff && !b_adv;

   // newest row: written at accept, read before write gives the row above
   lsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line1 (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_addr),
      .wr_data (pix_now),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (lb1_q)
   );

   // older row: takes the row-above value one stage later
   lsf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line0 (
      .clock   (clock),
      .wr_en   (b_adv),
      .wr_addr (b_addr_ff),
      .wr_data (lb1_q),
      .rd_en   (accept),
      .rd_addr (col_addr),
      .rd_data (lb0_q)
   );

   // same column written and read on one edge (one pixel rows): bypass
   assign fwd_now = b_adv && (b_addr_ff == col_addr);
   assign lb0_eff = b_fwd_ff ? b_fwd_data_ff : lb0_q;

   assign newcol[0] = lb0_eff;
   assign newcol[1] = lb1_q;
   assign newcol[2] = b_pix_ff;

   // window with taps outside the image forced to zero
   always_comb begin
      win = '0;
      for (int r = 0; r < 3; r++) begin
         if (!((r == 0 && b_flags_ff.top_edge) || (r == 2 && b_flags_ff.bottom_edge))) begin
            if (!b_flags_ff.left_edge) begin
               win[r][0] = sr1_ff[r];
            end
            win[r][1] = sr0_ff[r];
            if (!b_flags_ff.right_edge) begin
               win[r][2] = newcol[r];
            end
         end
      end
   end

   lsf_filter u_filter (
      .win    (win),
      .mode   (mode),
      .result (result)
   );

   // next values of the stage and result registers
   always_comb begin
      b_valid_in    = accept ? 1'b1 : (b_adv ? 1'b0 : b_valid_ff);
      b_flags_in    = accept ? flags : b_flags_ff;
      b_pix_in      = accept ? pix_now : b_pix_ff;
      b_addr_in     = accept ? col_addr : b_addr_ff;
      b_fwd_in      = accept ? fwd_now : b_fwd_ff;
      b_fwd_data_in = accept ? lb1_q : b_fwd_data_ff;
      sr0_in        = b_adv ? newcol : sr0_ff;
      sr1_in        = b_adv ? sr0_ff : sr1_ff;
      out_valid_in  = (b_adv && b_flags_ff.has_result) || (out_valid_ff && rsp_stall);
      out_word_in   = out_word_ff;
      if (b_adv && b_flags_ff.has_result) begin
         out_word_in.pixel_out    = result;
         out_word_in.end_of_row   = b_flags_ff.end_of_row;
         out_word_in.end_of_frame = b_flags_ff.end_of_frame;
      end
   end

   // control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         sr0_ff       <= '0;
         sr1_ff       <= '0;
      end else begin
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         sr0_ff       <= sr0_in;
         sr1_ff       <= sr1_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      b_flags_ff    <= b_flags_in;
      b_pix_ff      <= b_pix_in;
      b_addr_ff     <= b_addr_in;
      b_fwd_ff      <= b_fwd_in;
      b_fwd_data_ff <= b_fwd_data_in;
      out_word_ff   <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_word_ff;

endmodule

### rtl/core/laplacian_sobel_filter_3x3.sv
// top level of the 3x3 laplacian sharpen / sobel gradient filter
// depends on lsf_pkg, lsf_ctrl and lsf_window
//
// Usage:
//   req channel takes one word per pixel in raster order (pixel_in, drain);
//   after the last pixel of a frame the source sends image_width + 1 drain
//   words. rsp channel gives one filtered pixel per image position with
//   end_of_row / end_of_frame flags. A word moves on an edge where valid is
//   high and stall is low.
//   csr port: filter_mode, image_width, image_height, written while idle;
//   a size write restarts the frame.
// Timing:
//   one word per clock sustained while no result is held on rsp. The result for
//   position k is shown on rsp once word k + image_width + 1 is taken, through
//   the line buffer read and then the window stage into the result register.
// Reset:
//   synchronous; counters clear, mode is laplacian, size min(MAX_WIDTH, 1024) x min(MAX_HEIGHT, 1024).
//   Line buffers need no clearing.
// Stall:
//   while rsp_stall holds a result, words are still taken until one that has
//   a result waits in the window stage; req_stall then stays high with it.
module laplacian_sobel_filter_3x3 import lsf_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_word_type          rsp_data,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);

   logic            accept;
   logic [AW-1:0]   col_addr;
   pos_flags_type   flags;
   filter_mode_type mode;

   assign accept = req_valid && !req_stall;

   // registers and position counters
   lsf_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .accept       (accept),
      .col_addr     (col_addr),
      .flags        (flags),
      .mode         (mode)
   );

   // line buffers, window and result register
   lsf_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .word      (req_data),
      .col_addr  (col_addr),
      .flags     (flags),
      .mode      (mode),
      .stall     (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/core/lsf_checker.sv
// port level checks of the filter top, attached by bind
// depends on lsf_pkg and laplacian_sobel_filter_3x3
module lsf_checker import lsf_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_word_type          rsp_data
);

   // a held result keeps its word
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result word changed");

   // frame end is always also a row end
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.end_of_frame || rsp_data.end_of_row))
      else $error("end_of_frame without end_of_row");

   // input backpressure only while a result is held downstream
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held result");

   // reset empties the pipeline
   assert property (@(posedge clock)
      reset |=> (!rsp_valid && !req_stall))
      else $error("pipeline not empty after reset");

endmodule

bind laplacian_sobel_filter_3x3 lsf_checker u_checker (.*);
